// ----- hw/rtl/awpp_pkg.sv -----
// Shared constants, types and arithmetic helpers for the windowed peak-to-peak detector.
`timescale 1ns / 1ps
`default_nettype none

package awpp_pkg;

  // Block configuration
  localparam int WINDOW_SAMPLES  = 16;
  localparam int SCANS_PER_FRAME = 256;
  localparam int BUFFER_COUNT    = 2;
  localparam int NUM_CH          = 3;

  // Field widths
  localparam int SAMPLE_W    = 12;
  localparam int SCALED_W    = 16;
  localparam int TIME_W      = 32;
  localparam int GAIN_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Counter widths
  localparam int WIN_CNT_W  = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int SCAN_CNT_W = (SCANS_PER_FRAME > 1) ? $clog2(SCANS_PER_FRAME) : 1;
  localparam int BUF_W      = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;

  // Empty-window minimum marker
  localparam logic [SCALED_W-1:0] MIN_INIT = '1;

  // Register reset values
  localparam logic              PAUSED_RST  = 1'b0;
  localparam logic              COLLECT_RST = 1'b1;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 32'd65536;
  localparam logic [TIME_W-1:0] PERIOD_RST  = 32'd1000;

  // Reciprocal of the window length: ceil(2^32 / N), exact for 16-bit dividends
  localparam int DIV_RECIP_W = 33;
  localparam logic [63:0] DIV_RECIP_WIDE =
    ((64'd1 << 32) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES);
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_WIDE[DIV_RECIP_W-1:0];

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAUSED         = 2'd0,
    REG_COLLECT_ENABLE = 2'd1,
    REG_SCALE_GAIN     = 2'd2,
    REG_GATE_PERIOD    = 2'd3
  } cfg_index_t;

  typedef logic [SCALED_W-1:0] scaled_t;

  // Q16.16 gain: keep product bits 31:16
  function automatic scaled_t scale_sample(input logic [SAMPLE_W-1:0] raw,
                                           input logic [GAIN_W-1:0] gain);
    logic [SAMPLE_W+GAIN_W-1:0] prod;
    prod = (SAMPLE_W + GAIN_W)'(raw) * (SAMPLE_W + GAIN_W)'(gain);
    return prod[31:16];
  endfunction

  // Truncating divide by the window length through the reciprocal
  function automatic scaled_t div_window(input scaled_t x);
    logic [SCALED_W+DIV_RECIP_W-1:0] prod;
    prod = (SCALED_W + DIV_RECIP_W)'(x) * (SCALED_W + DIV_RECIP_W)'(DIV_RECIP);
    return prod[32 +: SCALED_W];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/awpp_if.sv -----
// Valid/ready channel interfaces for scan input items and swing result items.
`timescale 1ns / 1ps
`default_nettype none

interface awpp_scan_if;
  import awpp_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_a;
  logic [SAMPLE_W-1:0] sample_b;
  logic [SAMPLE_W-1:0] sample_c;
  logic [TIME_W-1:0]   time_us;

  modport source (output valid, sample_a, sample_b, sample_c, time_us, input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c, time_us, output ready);
endinterface

interface awpp_swing_if;
  import awpp_pkg::*;
  logic                valid;
  logic                ready;
  logic                window_done;
  logic [SCALED_W-1:0] swing_a;
  logic [SCALED_W-1:0] swing_b;
  logic [SCALED_W-1:0] swing_c;
  logic [TIME_W-1:0]   record_time_us;
  logic                frame_done;
  logic                filled_buffer;

  modport source (output valid, window_done, swing_a, swing_b, swing_c, record_time_us,
                  frame_done, filled_buffer, input ready);
  modport sink   (input valid, window_done, swing_a, swing_b, swing_c, record_time_us,
                  frame_done, filled_buffer, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adc_window_peak_to_peak.sv -----
// Top level of the windowed peak-to-peak detector for three-channel scans.
// A scan's result item passes through the scale, window update and swing output registers in turn.
// Throughput: one scan per cycle; the three registers (scale, window update,
// swing output) advance together whenever the output register is empty or taken.
// Reset (rst, synchronous): registers return to defaults, window and frame
// counters clear, minimum set to all ones, maximum to zero, pipeline emptied.
`timescale 1ns / 1ps
`default_nettype none

module adc_window_peak_to_peak (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire awpp_pkg::cfg_index_t           cfg_index,
  input  wire logic [awpp_pkg::CFG_DATA_W-1:0] cfg_data,
  awpp_scan_if.sink                           scan,
  awpp_swing_if.source                        swing
);
  import awpp_pkg::*;

  // Configuration registers
  logic              paused;
  logic              collect_enable;
  logic [GAIN_W-1:0] scale_gain;
  logic [TIME_W-1:0] gate_period_us;

  // Pipeline control
  logic adv;

  // Stage 1: scaled samples
  logic              s1_valid;
  scaled_t           s1_scaled [NUM_CH];
  logic [TIME_W-1:0] s1_time;

  // Window and frame state
  logic [WIN_CNT_W-1:0]  window_count;
  scaled_t               run_min [NUM_CH];
  scaled_t               run_max [NUM_CH];
  logic [TIME_W-1:0]     last_gate_time;
  logic [SCAN_CNT_W-1:0] scan_count;
  logic [BUF_W-1:0]      work_buffer;
  logic [BUF_W-1:0]      last_filled;

  // Stage 2 combinational results
  logic                  gate_open;
  logic                  win_full;
  logic                  frame_full;
  logic [WIN_CNT_W:0]    win_cnt_inc;
  logic [SCAN_CNT_W:0]   scan_cnt_inc;
  logic [TIME_W-1:0]     elapsed;
  scaled_t               min_upd [NUM_CH];
  scaled_t               max_upd [NUM_CH];
  logic [BUF_W-1:0]      work_buffer_next;

  // Stage 2 registers
  logic              s2_valid;
  logic              s2_wdone;
  scaled_t           s2_mn [NUM_CH];
  scaled_t           s2_mx [NUM_CH];
  logic [TIME_W-1:0] s2_time;
  logic              s2_fdone;
  logic [BUF_W-1:0]  s2_filled;

  // Stage 3 combinational swing
  scaled_t swing_val [NUM_CH];

  // Output register
  logic              out_valid;
  logic              out_wdone;
  scaled_t           out_swing [NUM_CH];
  logic [TIME_W-1:0] out_time;
  logic              out_fdone;
  logic              out_filled;

  // Advance all stages when the output register is free
  assign adv        = !out_valid || swing.ready;
  assign scan.ready = adv;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      paused         <= PAUSED_RST;
      collect_enable <= COLLECT_RST;
      scale_gain     <= GAIN_RST;
      gate_period_us <= PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAUSED:         paused         <= cfg_data[0];
        REG_COLLECT_ENABLE: collect_enable <= cfg_data[0];
        REG_SCALE_GAIN:     scale_gain     <= cfg_data[GAIN_W-1:0];
        REG_GATE_PERIOD:    gate_period_us <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: drop paused items, scale the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= scan.valid && !paused;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_scaled[0] <= scale_sample(scan.sample_a, scale_gain);
      s1_scaled[1] <= scale_sample(scan.sample_b, scale_gain);
      s1_scaled[2] <= scale_sample(scan.sample_c, scale_gain);
      s1_time      <= scan.time_us;
    end
  end

  // Stage 2: gate check, running min/max, window and frame counters
  always_comb begin
    elapsed      = s1_time - last_gate_time;
    gate_open    = collect_enable && (elapsed >= gate_period_us);
    win_cnt_inc  = {1'b0, window_count} + (WIN_CNT_W + 1)'(1);
    win_full     = gate_open && (win_cnt_inc >= (WIN_CNT_W + 1)'(WINDOW_SAMPLES));
    scan_cnt_inc = {1'b0, scan_count} + (SCAN_CNT_W + 1)'(1);
    frame_full   = scan_cnt_inc >= (SCAN_CNT_W + 1)'(SCANS_PER_FRAME);
    if (work_buffer == BUF_W'(BUFFER_COUNT - 1)) begin
      work_buffer_next = '0;
    end else begin
      work_buffer_next = work_buffer + BUF_W'(1);
    end
    for (int c = 0; c < NUM_CH; c++) begin
      min_upd[c] = (s1_scaled[c] < run_min[c]) ? s1_scaled[c] : run_min[c];
      max_upd[c] = (s1_scaled[c] > run_max[c]) ? s1_scaled[c] : run_max[c];
    end
  end

  // Update window and frame state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count   <= '0;
      last_gate_time <= '0;
      scan_count     <= '0;
      work_buffer    <= '0;
      last_filled    <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        run_min[c] <= MIN_INIT;
        run_max[c] <= '0;
      end
    end else if (adv && s1_valid) begin
      if (gate_open) begin
        last_gate_time <= s1_time;
        if (win_full) begin
          window_count <= '0;
          for (int c = 0; c < NUM_CH; c++) begin
            run_min[c] <= MIN_INIT;
            run_max[c] <= '0;
          end
        end else begin
          window_count <= win_cnt_inc[WIN_CNT_W-1:0];
          for (int c = 0; c < NUM_CH; c++) begin
            run_min[c] <= min_upd[c];
            run_max[c] <= max_upd[c];
          end
        end
      end
      if (frame_full) begin
        scan_count  <= '0;
        last_filled <= work_buffer;
        work_buffer <= work_buffer_next;
      end else begin
        scan_count <= scan_cnt_inc[SCAN_CNT_W-1:0];
      end
    end
  end

  // Register window extremes; zero them when no window completed
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_wdone  <= win_full;
      s2_time   <= win_full ? s1_time : '0;
      s2_fdone  <= frame_full;
      s2_filled <= frame_full ? work_buffer : last_filled;
      for (int c = 0; c < NUM_CH; c++) begin
        if (win_full) begin
          s2_mx[c] <= max_upd[c];
          s2_mn[c] <= (min_upd[c] == MIN_INIT) ? max_upd[c] : min_upd[c];
        end else begin
          s2_mx[c] <= '0;
          s2_mn[c] <= '0;
        end
      end
    end
  end

  // Stage 3: divide extremes by the window length and take the difference
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (div_window(s2_mx[c]) >= div_window(s2_mn[c])) begin
        swing_val[c] = div_window(s2_mx[c]) - div_window(s2_mn[c]);
      end else begin
        swing_val[c] = '0;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_wdone  <= s2_wdone;
      out_time   <= s2_time;
      out_fdone  <= s2_fdone;
      out_filled <= s2_filled[0];
      for (int c = 0; c < NUM_CH; c++) begin
        out_swing[c] <= swing_val[c];
      end
    end
  end

  assign swing.valid          = out_valid;
  assign swing.window_done    = out_wdone;
  assign swing.swing_a        = out_swing[0];
  assign swing.swing_b        = out_swing[1];
  assign swing.swing_c        = out_swing[2];
  assign swing.record_time_us = out_time;
  assign swing.frame_done     = out_fdone;
  assign swing.filled_buffer  = out_filled;

endmodule

`default_nettype wire

// ----- bench/awpp_checker.sv -----
// Scoreboard for the peak-to-peak detector: predicts each swing item from accepted scans.
`timescale 1ns / 1ps
`default_nettype none

module awpp_checker
  import awpp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire cfg_index_t            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  awpp_scan_if                       scan,
  awpp_swing_if                      swing,
  output int                         errors,
  output int                         pending,
  output int                         results_seen,
  output int                         windows_seen,
  output int                         frames_seen
);

  typedef struct packed {
    logic                window_done;
    scaled_t             swing_a;
    scaled_t             swing_b;
    scaled_t             swing_c;
    logic [TIME_W-1:0]   record_time_us;
    logic                frame_done;
    logic                filled_buffer;
  } swing_item_t;

  // Register copies
  logic              is_paused;
  logic              collect_on;
  logic [GAIN_W-1:0] gain_q16;
  logic [TIME_W-1:0] gate_period;

  // Window and frame state
  int                win_fill;
  scaled_t           ch_min [NUM_CH];
  scaled_t           ch_max [NUM_CH];
  logic [TIME_W-1:0] gate_time;
  int                scans_in_frame;
  int                work_buf;
  logic              filled_buf;

  swing_item_t       expected_swings [$];
  int                err_cnt;
  int                result_cnt;
  int                window_cnt;
  int                frame_cnt;

  // Q16.16 gain, keep the low 16 bits of the integer part
  function automatic scaled_t apply_gain(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W+GAIN_W-1:0] prod;
    prod = (SAMPLE_W + GAIN_W)'(raw) * (SAMPLE_W + GAIN_W)'(gain_q16);
    return prod[31:16];
  endfunction

  // Advance the window and frame state by one scan and build its swing item
  function automatic swing_item_t track_scan(input logic [SAMPLE_W-1:0] a,
                                             input logic [SAMPLE_W-1:0] b,
                                             input logic [SAMPLE_W-1:0] c,
                                             input logic [TIME_W-1:0]   t);
    scaled_t           scaled [NUM_CH];
    scaled_t           diff   [NUM_CH];
    scaled_t           hi;
    scaled_t           lo;
    logic [TIME_W-1:0] elapsed;
    swing_item_t       item;
    item = '0;
    scaled[0] = apply_gain(a);
    scaled[1] = apply_gain(b);
    scaled[2] = apply_gain(c);
    elapsed = t - gate_time;
    if (collect_on && elapsed >= gate_period) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (scaled[ch] < ch_min[ch]) ch_min[ch] = scaled[ch];
        if (scaled[ch] > ch_max[ch]) ch_max[ch] = scaled[ch];
      end
      win_fill++;
      if (win_fill >= WINDOW_SAMPLES) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          hi = ch_max[ch];
          // an untouched minimum falls back to the maximum
          lo = (ch_min[ch] == MIN_INIT) ? hi : ch_min[ch];
          hi = hi / scaled_t'(WINDOW_SAMPLES);
          lo = lo / scaled_t'(WINDOW_SAMPLES);
          diff[ch] = (hi >= lo) ? scaled_t'(hi - lo) : scaled_t'(0);
          ch_min[ch] = MIN_INIT;
          ch_max[ch] = '0;
        end
        win_fill = 0;
        item.window_done    = 1'b1;
        item.swing_a        = diff[0];
        item.swing_b        = diff[1];
        item.swing_c        = diff[2];
        item.record_time_us = t;
      end
      gate_time = t;
    end
    // Count scans per frame and rotate the capture buffer
    scans_in_frame++;
    if (scans_in_frame >= SCANS_PER_FRAME) begin
      scans_in_frame = 0;
      filled_buf = work_buf[0];
      work_buf++;
      if (work_buf >= BUFFER_COUNT) work_buf = 0;
      item.frame_done = 1'b1;
    end
    item.filled_buffer = filled_buf;
    return item;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  initial begin
    err_cnt    = 0;
    result_cnt = 0;
    window_cnt = 0;
    frame_cnt  = 0;
  end

  always @(posedge clk) begin
    swing_item_t got;
    swing_item_t want;
    swing_item_t pred;
    if (rst) begin
      // Return predictor to its reset state
      is_paused      = PAUSED_RST;
      collect_on     = COLLECT_RST;
      gain_q16       = GAIN_RST;
      gate_period    = PERIOD_RST;
      win_fill       = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        ch_min[ch] = MIN_INIT;
        ch_max[ch] = '0;
      end
      gate_time      = '0;
      scans_in_frame = 0;
      work_buf       = 0;
      filled_buf     = 1'b0;
      expected_swings.delete();
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PAUSED:         is_paused   = cfg_data[0];
          REG_COLLECT_ENABLE: collect_on  = cfg_data[0];
          REG_SCALE_GAIN:     gain_q16    = cfg_data[GAIN_W-1:0];
          REG_GATE_PERIOD:    gate_period = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      // Predict accepted scans; paused scans leave no trace
      if (scan.valid && scan.ready && !is_paused) begin
        pred = track_scan(scan.sample_a, scan.sample_b, scan.sample_c, scan.time_us);
        expected_swings.insert(expected_swings.size(), pred);
      end
      // Compare each accepted swing item with the oldest prediction
      if (swing.valid && swing.ready) begin
        got.window_done    = swing.window_done;
        got.swing_a        = swing.swing_a;
        got.swing_b        = swing.swing_b;
        got.swing_c        = swing.swing_c;
        got.record_time_us = swing.record_time_us;
        got.frame_done     = swing.frame_done;
        got.filled_buffer  = swing.filled_buffer;
        result_cnt++;
        if (got.window_done === 1'b1) window_cnt++;
        if (got.frame_done === 1'b1) frame_cnt++;
        if (expected_swings.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected swing item, expected none, actual 0x%0h", $time, got);
        end else begin
          want = expected_swings.pop_front();
          check_field("window_done", 32'(want.window_done), 32'(got.window_done));
          check_field("swing_a", 32'(want.swing_a), 32'(got.swing_a));
          check_field("swing_b", 32'(want.swing_b), 32'(got.swing_b));
          check_field("swing_c", 32'(want.swing_c), 32'(got.swing_c));
          check_field("record_time_us", want.record_time_us, got.record_time_us);
          check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
          check_field("filled_buffer", 32'(want.filled_buffer), 32'(got.filled_buffer));
        end
      end
    end
    errors       <= err_cnt;
    pending      <= expected_swings.size();
    results_seen <= result_cnt;
    windows_seen <= window_cnt;
    frames_seen  <= frame_cnt;
  end

endmodule

`default_nettype wire

// ----- bench/tb_adc_window_peak_to_peak.sv -----
// Testbench top for the peak-to-peak detector: clock, reset, scan stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_adc_window_peak_to_peak;
  import awpp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  awpp_scan_if  scan_ch ();
  awpp_swing_if swing_ch ();

  int                errors;
  int                pending;
  int                results_seen;
  int                windows_seen;
  int                frames_seen;
  int                scans_sent;
  int                cycle_count;
  logic [TIME_W-1:0] now_us;
  logic [TIME_W-1:0] cur_period;
  bit                hold_req;

  adc_window_peak_to_peak u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan_ch),
    .swing     (swing_ch)
  );

  awpp_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .scan         (scan_ch),
    .swing        (swing_ch),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .windows_seen (windows_seen),
    .frames_seen  (frames_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // End the run if it hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_code();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return SAMPLE_W'($urandom_range(0, 4095));
  endfunction

  // Mostly step forward around the gate period, sometimes jump anywhere or back
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1:    return (cur_period != 0) ? now_us + $urandom_range(0, cur_period - 1) : now_us;
      2:       return now_us + cur_period;
      8:       return $urandom();
      9:       return now_us - $urandom_range(1, 50);
      default: return now_us + cur_period + $urandom_range(0, 2000);
    endcase
  endfunction

  // Offer one scan item and hold it until accepted
  task automatic send_scan(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                           input logic [SAMPLE_W-1:0] c, input logic [TIME_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      scan_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_ch.valid    <= 1'b1;
    scan_ch.sample_a <= a;
    scan_ch.sample_b <= b;
    scan_ch.sample_c <= c;
    scan_ch.time_us  <= t;
    do @(posedge clk); while (!scan_ch.ready);
    scans_sent++;
    now_us = t;
  endtask

  // Drop valid and wait until every predicted item has come out
  task automatic wait_idle();
    scan_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back
  task automatic apply_setting(input logic pause, input logic collect,
                               input logic [GAIN_W-1:0] gain, input logic [TIME_W-1:0] period);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PAUSED;
    cfg_data  <= CFG_DATA_W'(pause);
    @(posedge clk);
    cfg_index <= REG_COLLECT_ENABLE;
    cfg_data  <= CFG_DATA_W'(collect);
    @(posedge clk);
    cfg_index <= REG_SCALE_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    cfg_index <= REG_GATE_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cur_period  = period;
  endtask

  task automatic run_phase(input logic pause, input logic collect,
                           input logic [GAIN_W-1:0] gain, input logic [TIME_W-1:0] period,
                           input int count);
    wait_idle();
    apply_setting(pause, collect, gain, period);
    repeat (count) send_scan(pick_code(), pick_code(), pick_code(), pick_time());
  endtask

  // Result side: ready in random bursts, one long hold-off on request
  initial begin
    int run;
    int stall;
    swing_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      swing_ch.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        swing_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    hold_req         = 1'b0;
    scans_sent       = 0;
    now_us           = '0;
    cur_period       = PERIOD_RST;
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= REG_PAUSED;
    cfg_data         <= '0;
    scan_ch.valid    <= 1'b0;
    scan_ch.sample_a <= '0;
    scan_ch.sample_b <= '0;
    scan_ch.sample_c <= '0;
    scan_ch.time_us  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Full window of saturated scaled samples: minimum never drops below all ones,
    // third channel mixes overflow wrap and zero
    apply_setting(1'b0, 1'b1, 32'hFFFF_0000, '0);
    for (int i = 0; i < WINDOW_SAMPLES; i++) begin
      send_scan(12'd1, 12'd1, (i % 3 == 0) ? 12'hFFF : (i % 3 == 1) ? 12'h000 : 12'h800,
                TIME_W'(i));
    end

    // Default gain and period: closed gate, exact boundary, timestamp wrap
    wait_idle();
    apply_setting(1'b0, 1'b1, GAIN_RST, PERIOD_RST);
    send_scan(12'h000, 12'hFFF, 12'h800, 32'd500);
    send_scan(12'hFFF, 12'h000, 12'h001, 32'd1015);
    send_scan(12'h001, 12'h002, 12'h003, 32'd2014);
    send_scan(12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FF00);
    send_scan(12'h000, 12'h000, 12'h000, 32'h0000_02E8);
    send_scan(12'hFFF, 12'h000, 12'hFFF, 32'h0000_02E9);

    // Paused scans must vanish without touching state
    wait_idle();
    apply_setting(1'b1, 1'b1, GAIN_RST, PERIOD_RST);
    send_scan(12'hABC, 12'h123, 12'hFFF, 32'h0001_0000);
    send_scan(12'h000, 12'hFFF, 12'h555, 32'h0002_0000);

    // Random phases across register settings; first one stalls the result side
    hold_req = 1'b1;
    run_phase(1'b0, 1'b1, GAIN_RST, PERIOD_RST, 300);
    run_phase(1'b0, 1'b1, 32'hFFFF_FFFF, '0, 220);
    run_phase(1'b0, 1'b1, $urandom(), $urandom_range(1, 5000), 220);
    run_phase(1'b0, 1'b1, '0, PERIOD_RST, 100);
    run_phase(1'b0, 1'b0, GAIN_RST, '0, 100);
    run_phase(1'b1, 1'b1, GAIN_RST, '0, 60);
    run_phase(1'b0, 1'b1, GAIN_RST, 32'hFFFF_FFFF, 150);
    run_phase(1'b0, 1'b1, $urandom(), $urandom_range(0, 3000), 300);
    run_phase(1'b0, 1'b1, 32'h0010_0000, 32'd500, 250);
    run_phase(1'b0, 1'b1, 32'h0020_0000, '0, 150);
    wait_idle();

    $display("Covered %0d scans, %0d swing items, %0d completed windows, %0d frames,",
             scans_sent, results_seen, windows_seen, frames_seen);
    $display("over gain, gate period, collect and pause settings including their extremes.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
